FILE: rtl/core/sfc_pkg.sv
// sfc_pkg: shared constants and types for the SAM statistics / FASTX converter
// no dependencies; imported by the result channel interface, the top level and the bench

package sfc_pkg;

  localparam int unsigned COUNT_WIDTH = 48;  // internal counter width
  localparam int unsigned OUT_CNT_W   = 48;  // counter fields on the result beat
  localparam int unsigned COL_W       = 4;
  localparam int unsigned RUN_MAX     = 4;   // most result beats per input byte
  localparam int unsigned RUN_IDX_W   = $clog2(RUN_MAX);
  localparam int unsigned RUN_CNT_W   = $clog2(RUN_MAX + 1);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  localparam logic [COL_W-1:0] COL_ID   = 4'd1;
  localparam logic [COL_W-1:0] COL_SEQ  = 4'd10;
  localparam logic [COL_W-1:0] COL_QUAL = 4'd11;
  localparam logic [COL_W-1:0] COL_MAX  = 4'd15;

  typedef enum logic [1:0] {
    FMT_NONE  = 2'd0,
    FMT_FASTQ = 2'd1,
    FMT_FASTA = 2'd2,
    FMT_SAM   = 2'd3
  } fmt_e;

  // one input byte's worth of result beats
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0]  bytes;
    logic [RUN_IDX_W-1:0]     last_idx;
    logic                     byte_valid;
    logic [OUT_CNT_W-1:0]     header_lines;
    logic [OUT_CNT_W-1:0]     read_lines;
    logic [OUT_CNT_W-1:0]     sequence_bases;
  } run_t;

endpackage

FILE: rtl/core/sfc_if.sv
// sfc_if: valid/ready channel interfaces for the input, result and config beats
// depends on sfc_pkg for field widths

interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface sfc_out_if;
  import sfc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_byte;
  logic                 byte_valid;
  logic                 last_of_run;
  logic [OUT_CNT_W-1:0] header_lines;
  logic [OUT_CNT_W-1:0] read_lines;
  logic [OUT_CNT_W-1:0] sequence_bases;

  modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                  output header_lines, output read_lines, output sequence_bases,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last_of_run,
                  input header_lines, input read_lines, input sequence_bases,
                  output ready);
endinterface

interface sfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] fmt_sel;

  modport source (output valid, output fmt_sel, input ready);
  modport sink   (input valid, input fmt_sel, output ready);
endinterface

FILE: rtl/core/sam_stats_fastx_converter.sv
// sam_stats_fastx_converter: SAM byte stream statistics and FASTQ/FASTA/SAM emitter
// depends on sfc_pkg and the channel interfaces in sfc_if.sv

// Takes one SAM text byte per beat and turns it into a run of one to four result
// beats; every beat carries the header, read and base counts after that byte, and
// the final beat of a run has last_of_run set. A byte is parsed in the cycle it is
// accepted and its whole run is written into the output run register, or into the
// pending slot while a run is still going out, so a byte that yields a single beat
// flows at one byte per clock while the output is ready. A longer run holds the
// output, one beat per cycle from the run register while the output is ready; the
// pending slot takes the next byte meanwhile. Each beat is driven from the run
// register, not straight from the input. The format select may only change while
// the block is idle; config writes are always ready.

module sam_stats_fastx_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfc_cfg_if.sink   cfg_i,
  sfc_in_if.sink    in_i,
  sfc_out_if.source out_o
);
  import sfc_pkg::*;

  fmt_e                   fmt_q;
  logic [COL_W-1:0]       col_q, col_d;
  logic                   started_q, started_d;
  logic                   hdr_q, hdr_d;
  logic [COUNT_WIDTH-1:0] hc_q, hc_d, rc_q, rc_d, bc_q, bc_d;

  run_t                   run_q, pend_q, new_run;
  logic                   run_valid_q, pend_valid_q;
  logic [RUN_IDX_W-1:0]   k_q;

  logic [RUN_MAX-1:0][7:0] emit;
  logic [RUN_CNT_W-1:0]    n;
  logic [7:0]              c;
  logic                    seq_mode, first;
  logic                    in_fire, out_fire, run_done, load_run;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !pend_valid_q;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;
  assign run_done    = out_fire && (k_q == run_q.last_idx);
  assign load_run    = !run_valid_q || run_done;

  // parse the byte and build its run of beats
  always_comb begin
    c         = in_i.in_byte;
    seq_mode  = (fmt_q == FMT_FASTQ) || (fmt_q == FMT_FASTA);
    first     = !started_q;
    col_d     = col_q;
    started_d = started_q;
    hdr_d     = hdr_q;
    hc_d      = hc_q;
    rc_d      = rc_q;
    bc_d      = bc_q;
    emit      = '0;
    n         = '0;

    if (fmt_q == FMT_SAM) begin
      emit[n[RUN_IDX_W-1:0]] = c;
      n = n + 1'b1;
    end

    if (c == CH_LF) begin
      col_d     = COL_ID;
      started_d = 1'b0;
      if (!hdr_q && seq_mode) begin
        emit[n[RUN_IDX_W-1:0]] = CH_LF;
        n = n + 1'b1;
      end
    end else if (c == CH_TAB) begin
      if (col_q != COL_MAX) begin
        col_d = col_q + 1'b1;
      end
      started_d = 1'b0;
    end else begin
      started_d = 1'b1;
      if (col_q == COL_ID) begin
        if (first) begin
          if (c == CH_AT) begin
            hc_d = (hc_q == CNT_MAX) ? hc_q : hc_q + 1'b1;
          end else begin
            hdr_d = 1'b0;
            rc_d  = (rc_q == CNT_MAX) ? rc_q : rc_q + 1'b1;
            if (fmt_q == FMT_FASTQ) begin
              emit[n[RUN_IDX_W-1:0]] = CH_AT;
              n = n + 1'b1;
            end else if (fmt_q == FMT_FASTA) begin
              emit[n[RUN_IDX_W-1:0]] = CH_GT;
              n = n + 1'b1;
            end
          end
        end
        if (!hdr_d && seq_mode) begin
          emit[n[RUN_IDX_W-1:0]] = c;
          n = n + 1'b1;
        end
      end else if (col_q == COL_SEQ) begin
        bc_d = (bc_q == CNT_MAX) ? bc_q : bc_q + 1'b1;
        if (seq_mode) begin
          if (first) begin
            emit[n[RUN_IDX_W-1:0]] = CH_LF;
            n = n + 1'b1;
          end
          emit[n[RUN_IDX_W-1:0]] = c;
          n = n + 1'b1;
        end
      end else if (col_q == COL_QUAL) begin
        if (fmt_q == FMT_FASTQ) begin
          if (first) begin
            emit[0] = CH_LF;
            emit[1] = CH_PLUS;
            emit[2] = CH_LF;
            n = 3'd3;
          end
          emit[n[RUN_IDX_W-1:0]] = c;
          n = n + 1'b1;
        end
      end
    end

    new_run.bytes          = emit;
    new_run.byte_valid     = (n != '0);
    new_run.last_idx       = (n == '0) ? '0 : RUN_IDX_W'(n - 1'b1);
    new_run.header_lines   = OUT_CNT_W'(hc_d);
    new_run.read_lines     = OUT_CNT_W'(rc_d);
    new_run.sequence_bases = OUT_CNT_W'(bc_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_NONE;
      col_q     <= COL_ID;
      started_q <= 1'b0;
      hdr_q     <= 1'b1;
      hc_q      <= '0;
      rc_q      <= '0;
      bc_q      <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        fmt_q <= fmt_e'(cfg_i.fmt_sel);
      end
      if (in_fire) begin
        col_q     <= col_d;
        started_q <= started_d;
        hdr_q     <= hdr_d;
        hc_q      <= hc_d;
        rc_q      <= rc_d;
        bc_q      <= bc_d;
      end
    end
  end

  // run register plus one pending slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      k_q          <= '0;
    end else if (load_run) begin
      k_q          <= '0;
      run_valid_q  <= pend_valid_q || in_fire;
      pend_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        k_q <= k_q + 1'b1;
      end
      if (in_fire) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_run) begin
      run_q <= pend_valid_q ? pend_q : new_run;
    end else if (in_fire) begin
      pend_q <= new_run;
    end
  end

  assign out_o.valid          = run_valid_q;
  assign out_o.out_byte       = run_q.bytes[k_q];
  assign out_o.byte_valid     = run_q.byte_valid;
  assign out_o.last_of_run    = (k_q == run_q.last_idx);
  assign out_o.header_lines   = run_q.header_lines;
  assign out_o.read_lines     = run_q.read_lines;
  assign out_o.sequence_bases = run_q.sequence_bases;

  a_pend_behind_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> run_valid_q)
    else $error("pending slot filled while run register empty");

  a_beat_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> (k_q <= run_q.last_idx))
    else $error("beat index beyond end of run");

  a_run_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !run_done) |=> (run_valid_q && k_q == $past(k_q) + 1'b1))
    else $error("run did not advance to next beat");

  a_col_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q != '0)
    else $error("column index reached zero");

  a_header_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$rose(hdr_q))
    else $error("header phase re-entered");

endmodule

FILE: verif/sam_stats_fastx_converter_tb.sv
// sam_stats_fastx_converter_tb: self-checking bench for the SAM statistics / FASTX converter
// drives SAM text byte beats and format writes, checks every result beat against a predictor
// depends on sfc_pkg, the channel interfaces in sfc_if.sv and sam_stats_fastx_converter
`timescale 1ns / 100ps

module sam_stats_fastx_converter_tb;
  import sfc_pkg::*;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 last_of_run;
    logic [OUT_CNT_W-1:0] header_lines;
    logic [OUT_CNT_W-1:0] read_lines;
    logic [OUT_CNT_W-1:0] sequence_bases;
  } result_beat_t;

  // tracks the parser state and holds the beats each accepted byte should produce
  class fastx_scoreboard;
    fmt_e                   fmt         = FMT_NONE;
    logic [COL_W-1:0]       col         = COL_ID;
    bit                     col_started = 1'b0;
    bit                     in_header   = 1'b1;
    logic [COUNT_WIDTH-1:0] n_header    = '0;
    logic [COUNT_WIDTH-1:0] n_read      = '0;
    logic [COUNT_WIDTH-1:0] n_base      = '0;
    result_beat_t           expected_q[$];
    int unsigned            errors      = 0;

    function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] c);
      logic [7:0]   chars[$];
      bit           first;
      bit           seq_fmt;
      result_beat_t b;
      seq_fmt = (fmt == FMT_FASTQ) || (fmt == FMT_FASTA);
      if (fmt == FMT_SAM) chars.push_back(c);
      if (c == CH_LF) begin
        col = COL_ID;
        col_started = 1'b0;
        if (!in_header && seq_fmt) chars.push_back(CH_LF);
      end else if (c == CH_TAB) begin
        if (col < COL_MAX) col = col + 1'b1;
        col_started = 1'b0;
      end else begin
        first = !col_started;
        col_started = 1'b1;
        if (col == COL_ID) begin
          if (first) begin
            if (c == CH_AT) begin
              n_header = bump(n_header);
            end else begin
              in_header = 1'b0;
              n_read = bump(n_read);
              if (fmt == FMT_FASTQ) chars.push_back(CH_AT);
              else if (fmt == FMT_FASTA) chars.push_back(CH_GT);
            end
          end
          if (!in_header && seq_fmt) chars.push_back(c);
        end else if (col == COL_SEQ) begin
          n_base = bump(n_base);
          if (seq_fmt) begin
            if (first) chars.push_back(CH_LF);
            chars.push_back(c);
          end
        end else if (col == COL_QUAL) begin
          if (fmt == FMT_FASTQ) begin
            if (first) begin
              chars.push_back(CH_LF);
              chars.push_back(CH_PLUS);
              chars.push_back(CH_LF);
            end
            chars.push_back(c);
          end
        end
      end
      b.header_lines   = OUT_CNT_W'(n_header);
      b.read_lines     = OUT_CNT_W'(n_read);
      b.sequence_bases = OUT_CNT_W'(n_base);
      if (chars.size() == 0) begin
        b.out_byte    = 8'h00;
        b.byte_valid  = 1'b0;
        b.last_of_run = 1'b1;
        expected_q.push_back(b);
      end else begin
        foreach (chars[k]) begin
          b.out_byte    = chars[k];
          b.byte_valid  = 1'b1;
          b.last_of_run = (k == chars.size() - 1);
          expected_q.push_back(b);
        end
      end
    endfunction

    function void cmp_field(string name, logic [OUT_CNT_W-1:0] exp_v,
                            logic [OUT_CNT_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_beat(result_beat_t got);
      result_beat_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: out_byte %0h", got.out_byte);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("out_byte", OUT_CNT_W'(want.out_byte), OUT_CNT_W'(got.out_byte));
      cmp_field("byte_valid", OUT_CNT_W'(want.byte_valid), OUT_CNT_W'(got.byte_valid));
      cmp_field("last_of_run", OUT_CNT_W'(want.last_of_run), OUT_CNT_W'(got.last_of_run));
      cmp_field("header_lines", want.header_lines, got.header_lines);
      cmp_field("read_lines", want.read_lines, got.read_lines);
      cmp_field("sequence_bases", want.sequence_bases, got.sequence_bases);
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   burst = 1'b0;

  fastx_scoreboard book = new();
  result_beat_t    seen;
  logic [7:0]      line_q[$];

  sfc_cfg_if cfg_bus();
  sfc_in_if  in_bus();
  sfc_out_if out_bus();

  sam_stats_fastx_converter uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("sam_stats_fastx_converter_tb: errors");
    $finish;
  end

  // result sink: ready runs broken by stalls, mostly short, some long
  initial begin : sink_pacing
    int unsigned run_len;
    int unsigned stall;
    int unsigned r;
    out_bus.ready = 1'b0;
    forever begin
      run_len = $urandom_range(1, 40);
      r = $urandom_range(0, 99);
      if (r < 30) stall = 0;
      else if (r < 85) stall = $urandom_range(1, 3);
      else stall = $urandom_range(10, 30);
      repeat (run_len) begin
        @(negedge clk);
        out_bus.ready = 1'b1;
      end
      repeat (stall) begin
        @(negedge clk);
        out_bus.ready = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen.out_byte       = out_bus.out_byte;
      seen.byte_valid     = out_bus.byte_valid;
      seen.last_of_run    = out_bus.last_of_run;
      seen.header_lines   = out_bus.header_lines;
      seen.read_lines     = out_bus.read_lines;
      seen.sequence_bases = out_bus.sequence_bases;
      book.check_beat(seen);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // printable text, never a tab or a newline
  function automatic void add_text(int unsigned n);
    repeat (n) line_q.push_back(8'($urandom_range(33, 126)));
  endfunction

  function automatic void build_read_line(int unsigned n_cols);
    for (int unsigned c = 1; c <= n_cols; c++) begin
      if (c > 1) line_q.push_back(CH_TAB);
      if (c == COL_ID) begin
        add_text($urandom_range(1, 4));
      end else if (c == COL_SEQ) begin
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 4))
            0: line_q.push_back("A");
            1: line_q.push_back("C");
            2: line_q.push_back("G");
            3: line_q.push_back("T");
            default: line_q.push_back("N");
          endcase
        end
      end else if (c == COL_QUAL) begin
        add_text($urandom_range(0, 6));
      end else begin
        add_text($urandom_range(0, 2));
      end
    end
    line_q.push_back(CH_LF);
  endfunction

  function automatic void build_random_line();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      // well-formed record, now and then with enough columns to saturate the index
      if ($urandom_range(0, 4) == 0) build_read_line(11 + $urandom_range(5, 8));
      else build_read_line(11 + $urandom_range(0, 2));
    end else if (r < 75) begin
      build_read_line($urandom_range(1, 10));
    end else if (r < 85) begin
      line_q.push_back(CH_AT);
      add_text($urandom_range(0, 3));
      line_q.push_back(CH_TAB);
      add_text($urandom_range(1, 4));
      line_q.push_back(CH_LF);
    end else if (r < 92) begin
      line_q.push_back(CH_TAB);
      add_text($urandom_range(0, 4));
      line_q.push_back(CH_LF);
    end else begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(CH_LF);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   = 1'b1;
    in_bus.in_byte = b;
    do @(posedge clk); while (!in_bus.ready);
    book.note_byte(b);
  endtask

  task automatic send_line();
    burst = ($urandom_range(0, 3) == 0);
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  // stop sending and let every expected beat come out
  task automatic settle();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_format(input fmt_e f);
    @(negedge clk);
    cfg_bus.valid   = 1'b1;
    cfg_bus.fmt_sel = f;
    do @(posedge clk); while (!cfg_bus.ready);
    book.fmt = f;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  initial begin : stimulus
    fmt_e        phase_fmt[4];
    int unsigned sent;
    phase_fmt = '{FMT_FASTA, FMT_SAM, FMT_NONE, FMT_FASTQ};
    cfg_bus.valid   = 1'b0;
    cfg_bus.fmt_sel = FMT_NONE;
    in_bus.valid    = 1'b0;
    in_bus.in_byte  = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_format(FMT_FASTQ);
    // header line, a line opening with a tab, one record with extreme bytes,
    // then an '@' line once the header is over
    line_q = '{CH_AT, CH_TAB, "X", CH_LF, CH_TAB, CH_LF, 8'hFF};
    repeat (9) line_q.push_back(CH_TAB);
    line_q.push_back(8'h00);
    line_q.push_back(CH_TAB);
    line_q.push_back("I");
    line_q.push_back(CH_LF);
    line_q.push_back(CH_AT);
    line_q.push_back("x");
    line_q.push_back(CH_LF);
    send_line();
    settle();

    foreach (phase_fmt[p]) begin
      write_format(phase_fmt[p]);
      sent = 0;
      while (sent < 75) begin
        build_random_line();
        sent += line_q.size();
        send_line();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0)
      $display("sam_stats_fastx_converter_tb: clean");
    else
      $display("sam_stats_fastx_converter_tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sfc_pkg.sv
rtl/core/sfc_if.sv
rtl/core/sam_stats_fastx_converter.sv
verif/sam_stats_fastx_converter_tb.sv
